// ===== hw/rtl/mmwf_pkg.sv =====
// ----------------------------------------------------------------------------
// mmwf_pkg
// Shared types and constants of the 3x3 grey window median / mean filter.
// ----------------------------------------------------------------------------
package mmwf_pkg;

  localparam int unsigned RowWidth   = 512;
  localparam int unsigned ColW       = (RowWidth > 1) ? $clog2(RowWidth) : 1;

  localparam int unsigned GreyW      = 8;
  localparam int unsigned WinRows    = 3;
  localparam int unsigned WinCols    = 3;
  localparam int unsigned WinN       = WinRows * WinCols;
  localparam int unsigned MedIdx     = WinN / 2;
  localparam int unsigned CenterIdx  = WinN / 2;
  localparam int unsigned PixW       = 4;
  localparam int unsigned RowSelW    = 2;
  localparam int unsigned SortCntW   = $clog2(WinN);
  localparam int unsigned SortPhases = WinN;

  // grey = (r + g + b) / 3 as multiply by reciprocal
  localparam int unsigned RgbSumW    = 10;
  localparam int unsigned ThirdW     = 10;
  localparam logic [ThirdW-1:0] ThirdRecip = 10'd683;
  localparam int unsigned ThirdShift = 11;

  // weighted mean = acc / 10 as multiply by reciprocal
  localparam int unsigned AccW       = 12;
  localparam int unsigned TenthW     = 13;
  localparam logic [TenthW-1:0] TenthRecip = 13'd6554;
  localparam int unsigned TenthShift = 16;

  localparam logic RegFilterMode = 1'b0;

  typedef logic [GreyW-1:0] grey_t;
  typedef grey_t [WinN-1:0] win_t;

  typedef struct packed {
    logic load;
    logic step;
    logic keep_min;
    logic keep_max;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SORT,
    ST_MUL,
    ST_FIN
  } mmwf_state_e;

endpackage

// ===== hw/rtl/mmwf_sort_cell.sv =====
// ----------------------------------------------------------------------------
// mmwf_sort_cell
// One compare-exchange cell of the odd-even transposition sorter.
// ----------------------------------------------------------------------------
module mmwf_sort_cell
  import mmwf_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  grey_t      load_val_i,
  input  grey_t      left_val_i,
  input  grey_t      right_val_i,
  output grey_t      val_o
);

  grey_t val_q, val_d;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.load) begin
      val_d = load_val_i;
    end else if (ctrl_i.step) begin
      if (ctrl_i.keep_min) begin
        val_d = (right_val_i < val_q) ? right_val_i : val_q;
      end else if (ctrl_i.keep_max) begin
        val_d = (left_val_i > val_q) ? left_val_i : val_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

// ===== hw/rtl/mmwf_sort_chain.sv =====
// ----------------------------------------------------------------------------
// mmwf_sort_chain
// Row of nine sort cells; each step exchanges with the neighbor of the phase.
// ----------------------------------------------------------------------------
module mmwf_sort_chain
  import mmwf_pkg::*;
(
  input  logic  clk_i,
  input  logic  load_i,
  input  logic  step_i,
  input  logic  phase_i,
  input  win_t  win_i,
  output grey_t median_o
);

  grey_t      vals [WinN];
  cell_ctrl_t ctrl [WinN];

  for (genvar i = 0; i < WinN; i++) begin : g_cell
    grey_t left_val;
    grey_t right_val;

    if (i == 0) begin : g_first
      assign left_val = vals[i];
    end else begin : g_left
      assign left_val = vals[i-1];
    end

    if (i == WinN - 1) begin : g_last
      assign right_val = vals[i];
    end else begin : g_right
      assign right_val = vals[i+1];
    end

    assign ctrl[i].load     = load_i;
    assign ctrl[i].step     = step_i;
    assign ctrl[i].keep_min = (phase_i == 1'(i % 2)) && (i < WinN - 1);
    assign ctrl[i].keep_max = (phase_i != 1'(i % 2)) && (i > 0);

    mmwf_sort_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl[i]),
      .load_val_i  (win_i[i]),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .val_o       (vals[i])
    );
  end

  assign median_o = vals[MedIdx];

endmodule

// ===== hw/rtl/median_mean_window_filter_core.sv =====
// ----------------------------------------------------------------------------
// median_mean_window_filter_core
// 3x3 grey window filter over an RGB pixel stream, median or weighted mean.
// ----------------------------------------------------------------------------
// Each pixel becomes grey as (r+g+b)/3 and enters a 3x3 window: nine pixels at
// the first column of a row, three (the new right column, top to bottom) at
// every other column. A pixel that does not complete the window leaves the input
// free for the next pixel. The pixel that completes it holds the input stalled
// until the result is in the output register: the nine-cell sorter is loaded,
// nine odd-even transposition phases run in that cell row (the weighted sum
// accumulates in the same cycles), the reciprocal multiply of the mean is
// registered, and then the output register is filled. The result is held there
// until taken; a new window's result waits while the previous one is still stalled.
// filter_mode (address 0, bit 0): 0 median, 1 weighted mean 1 1 1/1 2 1/1 1 1
// divided by 10. The column count wraps at the row width of 512.
// ----------------------------------------------------------------------------
module median_mean_window_filter_core
  import mmwf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  filtered_grey_o
);

  mmwf_state_e state_q, state_d;

  logic [ColW-1:0]     col_q;
  logic [PixW-1:0]     pix_q;
  logic                mode_q;
  logic                out_valid_q;
  logic [SortCntW-1:0] sort_cnt_q;

  win_t                      win_q;
  logic [AccW-1:0]           acc_q;
  logic [AccW+TenthW-1:0]    prod_q;
  grey_t                     out_q;

  logic                      in_acc;
  logic                      cfg_wr;
  logic [RgbSumW-1:0]        rgb_sum;
  logic [RgbSumW+ThirdW-1:0] third_prod;
  grey_t                     grey;
  logic [PixW-1:0]           pix_inc;
  logic [PixW-1:0]           needed;
  logic                      complete;
  logic [RowSelW-1:0]        row_sel;
  grey_t                     median;

  logic cell_load;
  logic cell_step;
  logic mul_en;
  logic out_load;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == RegFilterMode);
  assign prdata = (paddr[2] == RegFilterMode) ? {31'b0, mode_q} : '0;

  // input side
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign rgb_sum    = RgbSumW'(red_i) + RgbSumW'(green_i) + RgbSumW'(blue_i);
  assign third_prod = rgb_sum * ThirdRecip;
  assign grey       = third_prod[ThirdShift +: GreyW];

  assign pix_inc  = pix_q + PixW'(1);
  assign needed   = (col_q == '0) ? PixW'(WinN) : PixW'(WinCols);
  assign complete = (pix_inc >= needed);
  assign row_sel  = (pix_q < PixW'(WinRows)) ? pix_q[RowSelW-1:0] : RowSelW'(WinRows - 1);

  // control
  always_comb begin
    state_d   = state_q;
    cell_load = 1'b0;
    cell_step = 1'b0;
    mul_en    = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && complete) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cell_load = 1'b1;
        state_d   = ST_SORT;
      end
      ST_SORT: begin
        cell_step = 1'b1;
        if (sort_cnt_q == SortCntW'(SortPhases - 1)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        mul_en  = 1'b1;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      pix_q       <= '0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
      sort_cnt_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load | (out_valid_q & out_stall_i);
      if (cfg_wr) begin
        mode_q <= pwdata[0];
      end
      if (in_acc) begin
        if (complete) begin
          pix_q <= '0;
          if (col_q == ColW'(RowWidth - 1)) begin
            col_q <= '0;
          end else begin
            col_q <= col_q + ColW'(1);
          end
        end else begin
          pix_q <= pix_inc;
        end
      end
      if (cell_load) begin
        sort_cnt_q <= '0;
      end else if (cell_step) begin
        sort_cnt_q <= sort_cnt_q + SortCntW'(1);
      end
    end
  end

  // window and datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (col_q == '0) begin
        for (int k = 0; k < WinN; k++) begin
          if (pix_q == PixW'(k)) begin
            win_q[k] <= grey;
          end
        end
      end else begin
        for (int r = 0; r < WinRows; r++) begin
          if (row_sel == RowSelW'(r)) begin
            win_q[r*WinCols]     <= win_q[r*WinCols + 1];
            win_q[r*WinCols + 1] <= win_q[r*WinCols + 2];
            win_q[r*WinCols + 2] <= grey;
          end
        end
      end
    end
    if (cell_load) begin
      acc_q <= AccW'(win_q[CenterIdx]);
    end else if (cell_step) begin
      acc_q <= acc_q + AccW'(win_q[sort_cnt_q]);
    end
    if (mul_en) begin
      prod_q <= acc_q * TenthRecip;
    end
    if (out_load) begin
      out_q <= mode_q ? prod_q[TenthShift +: GreyW] : median;
    end
  end

  mmwf_sort_chain u_sort_chain (
    .clk_i    (clk_i),
    .load_i   (cell_load),
    .step_i   (cell_step),
    .phase_i  (sort_cnt_q[0]),
    .win_i    (win_q),
    .median_o (median)
  );

  assign out_valid_o     = out_valid_q;
  assign filtered_grey_o = out_q;

  a_load_then_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD |=> state_q == ST_SORT)
    else $error("sorter load not followed by sort phases");

  a_sort_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SORT && sort_cnt_q == SortCntW'(SortPhases - 1)) |=> state_q == ST_MUL)
    else $error("sort did not end after the last phase");

  a_pix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_q <= PixW'(WinN - 1))
    else $error("window pixel count out of range");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_FIN)
    else $error("result shown without finishing a window");

endmodule
